// File: rtl/hnrc_pkg.sv
// hnrc_pkg: constants, codes and controller/datapath interface types
// for the hashed name roll call block; no dependencies
`timescale 1ns / 1ps

package hnrc_pkg;

	localparam int CAPACITY = 1024;
	localparam int HASH_W   = 64;
	localparam int CHAR_W   = 8;
	localparam int VERD_W   = 3;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = HASH_W + 1;

	localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [HASH_W-1:0] CHAR_BIAS = HASH_W'(96);

	// verdict codes
	localparam logic [VERD_W-1:0] V_STORED = 3'd0;
	localparam logic [VERD_W-1:0] V_FULL   = 3'd1;
	localparam logic [VERD_W-1:0] V_WRONG  = 3'd2;
	localparam logic [VERD_W-1:0] V_OK     = 3'd3;
	localparam logic [VERD_W-1:0] V_REPEAT = 3'd4;

	// request command codes
	localparam logic CMD_ROSTER = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// memory read address select
	localparam logic [1:0] RD_MID  = 2'd0;
	localparam logic [1:0] RD_JM1  = 2'd1;
	localparam logic [1:0] RD_LO   = 2'd2;

	// memory write select
	localparam logic [1:0] WR_SHIFT  = 2'd0;
	localparam logic [1:0] WR_INSERT = 2'd1;
	localparam logic [1:0] WR_MARK   = 2'd2;

	typedef struct packed {
		logic       hash_upd;
		logic       hash_end;
		logic       srch_step;
		logic       strict;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       j_load;
		logic       j_dec;
		logic       cnt_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic lo_lt_hi;
		logic j_gt_lo;
		logic lo_lt_cnt;
		logic key_eq;
		logic flag;
	} dp_sts_t;

endpackage

// File: rtl/hnrc_dp.sv
// hnrc_dp: datapath with running hash, sorted hash table memory,
// search bounds and entry count; uses hnrc_pkg
`timescale 1ns / 1ps

module hnrc_dp import hnrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [CHAR_W-1:0] char_code,
	output dp_sts_t           sts
);

	logic [HASH_W-1:0] partial_q;
	logic [HASH_W-1:0] key_q;
	logic [HASH_W-1:0] h_next;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  jm1;
	logic [CNT_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  wr_idx;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] mem [CAPACITY];
	logic [HASH_W-1:0] rhash;
	logic              go_right;

	// h * 131 + char - 96
	assign h_next = (partial_q << 7) + (partial_q << 1) + partial_q
		+ HASH_W'(char_code) - CHAR_BIAS;

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign jm1   = j_q - CNT_W'(1);
	assign rhash = rdata_q[HASH_W-1:0];
	assign go_right = cmd.strict ? (rhash <= key_q) : (rhash < key_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_MID:  rd_idx = mid;
			RD_JM1:  rd_idx = jm1;
			default: rd_idx = lo_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_idx  = j_q;
				wr_data = rdata_q;
			end
			WR_INSERT: begin
				wr_idx  = lo_q;
				wr_data = {1'b0, key_q};
			end
			default: begin
				wr_idx  = lo_q;
				wr_data = {1'b1, key_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.hash_end) begin
				partial_q <= '0;
			end else if (cmd.hash_upd) begin
				partial_q <= h_next;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_end) begin
			key_q <= h_next;
			lo_q  <= '0;
			hi_q  <= cnt_q;
		end else if (cmd.srch_step) begin
			if (go_right) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.j_load) begin
			j_q <= cnt_q;
		end else if (cmd.j_dec) begin
			j_q <= jm1;
		end
	end

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_idx[IDX_W-1:0]];
		end
		if (cmd.wr_en) begin
			mem[wr_idx[IDX_W-1:0]] <= wr_data;
		end
	end

	assign sts.full      = (cnt_q == CAP_CNT);
	assign sts.lo_lt_hi  = (lo_q < hi_q);
	assign sts.j_gt_lo   = (j_q > lo_q);
	assign sts.lo_lt_cnt = (lo_q < cnt_q);
	assign sts.key_eq    = (rhash == key_q);
	assign sts.flag      = rdata_q[HASH_W];

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT) else $error("entry count above capacity");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_step |-> lo_q < hi_q) else $error("search step on empty range");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> wr_idx <= cnt_q && cnt_q < CAP_CNT + CNT_W'(cmd.wr_sel == WR_MARK))
		else $error("table write outside filled range");
	a_inc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("entry count did not advance");
`endif

endmodule

// File: rtl/hnrc_ctrl.sv
// hnrc_ctrl: sequencer for hashing, binary search, shift insert and
// flag update, plus the result register; uses hnrc_pkg
`timescale 1ns / 1ps

module hnrc_ctrl import hnrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VERD_W-1:0] verdict,
	output dp_cmd_t           cmd,
	input  dp_sts_t           sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCHK  = 3'd1;
	localparam logic [2:0] ST_SCMP  = 3'd2;
	localparam logic [2:0] ST_SHCHK = 3'd3;
	localparam logic [2:0] ST_SHWR  = 3'd4;
	localparam logic [2:0] ST_QCMP  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic              mode_q;
	logic [VERD_W-1:0] pend_q;
	logic [VERD_W-1:0] pend_d;
	logic              pend_ld;
	logic              out_valid_q;
	logic [VERD_W-1:0] verdict_q;
	logic              in_acc;
	logic              res_ld;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign res_ld    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		pend_ld = 1'b0;
		cmd     = '0;
		cmd.strict = (mode_q == CMD_ROSTER);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.hash_upd = 1'b1;
					if (last_char) begin
						cmd.hash_end = 1'b1;
						if (command == CMD_ROSTER && sts.full) begin
							pend_d  = V_FULL;
							pend_ld = 1'b1;
							state_d = ST_DONE;
						end else begin
							state_d = ST_SCHK;
						end
					end
				end
			end
			ST_SCHK: begin
				if (sts.lo_lt_hi) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_MID;
					state_d    = ST_SCMP;
				end else if (mode_q == CMD_ROSTER) begin
					cmd.j_load = 1'b1;
					state_d    = ST_SHCHK;
				end else if (sts.lo_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LO;
					state_d    = ST_QCMP;
				end else begin
					pend_d  = V_WRONG;
					pend_ld = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_SCMP: begin
				cmd.srch_step = 1'b1;
				state_d       = ST_SCHK;
			end
			ST_SHCHK: begin
				if (sts.j_gt_lo) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_JM1;
					state_d    = ST_SHWR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_INSERT;
					cmd.cnt_inc = 1'b1;
					pend_d      = V_STORED;
					pend_ld     = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_SHWR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.j_dec  = 1'b1;
				state_d    = ST_SHCHK;
			end
			ST_QCMP: begin
				pend_ld = 1'b1;
				state_d = ST_DONE;
				if (!sts.key_eq) begin
					pend_d = V_WRONG;
				end else if (!sts.flag) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_MARK;
					pend_d     = V_OK;
				end else begin
					pend_d = V_REPEAT;
				end
			end
			ST_DONE: begin
				if (res_ld) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_char) begin
			mode_q <= command;
		end
		if (pend_ld) begin
			pend_q <= pend_d;
		end
		if (res_ld) begin
			verdict_q <= pend_q;
		end
	end

`ifndef SYNTHESIS
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_char |=> state_q != ST_IDLE) else $error("name end not processed");
	a_mid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !last_char |=> state_q == ST_IDLE && !$rose(out_valid_q))
		else $error("result raised without a name end");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not loaded from done");
`endif

endmodule

// File: rtl/hashed_name_roll_call.sv
// hashed_name_roll_call: top level, controller and datapath
// depends on hnrc_pkg, hnrc_ctrl, hnrc_dp
//
// channel  handshake            payload
// in       in_valid, in_stall   command, char_code, last_char
// out      out_valid, out_stall verdict
//
// a character that is not last only updates the running hash, and the input stays open for the next one
// a name end runs a binary search over the n entries of the sorted table,
// a roster then shifts every entry above the insert point up by one and writes the key
// a query then checks and sets the flag of the entry found (no check when the search ends past the last entry)
// a roster into a full table goes straight to its result; one result register is at the output
// reset clears the running hash, entry count and result valid; no clearing pass
// the output stall holds only a finished name end until its result is taken
`timescale 1ns / 1ps

module hashed_name_roll_call import hnrc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VERD_W-1:0] verdict
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	hnrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.cmd       (cmd),
		.sts       (sts)
	);

	hnrc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_code (char_code),
		.sts       (sts)
	);

endmodule
